>>> rtl/wnrl_pkg.sv
// Shared types and codes for the wildcard NAT rule lookup block.
package wnrl_pkg;

  localparam int unsigned KEY_W      = 48;
  localparam int unsigned VAL_W      = 48;
  localparam int unsigned IP_W       = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned NUM_STORES = 3;
  localparam int unsigned STORE_W    = 2;

  // Store index, also used as the match kind of a hit.
  localparam logic [STORE_W-1:0] STORE_EXACT    = 2'd0;
  localparam logic [STORE_W-1:0] STORE_IPONLY   = 2'd1;
  localparam logic [STORE_W-1:0] STORE_PORTONLY = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_HIT    = 2'd2;
  localparam logic [1:0] ST_MISS   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_CLAIM
  } op_e;

  // Token that walks down a row of cells, one cell per cycle.
  typedef struct packed {
    logic             active;
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             hit;        // key matched, or entry claimed
    logic             free_seen;  // an empty entry was passed
  } tok_t;

endpackage

>>> rtl/wnrl_cell.sv
// One rule entry: key, value and valid bit, with a token register to the next cell.
module wnrl_cell #(
  parameter int unsigned CELL_KEY_W = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wnrl_pkg::tok_t  tok_i,
  output wnrl_pkg::tok_t  tok_o
);

  logic                  valid_q, valid_d;
  logic [CELL_KEY_W-1:0] key_q;
  logic [wnrl_pkg::VAL_W-1:0] value_q;
  wnrl_pkg::tok_t        tok_q, tok_d;
  logic                  match;
  logic                  wr_key, wr_val;

  always_comb begin
    match   = valid_q && (key_q == tok_i.key[CELL_KEY_W-1:0]);
    tok_d   = tok_i;
    valid_d = valid_q;
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    if (tok_i.active) begin
      case (tok_i.op)
        wnrl_pkg::OP_LOOKUP: begin
          if (match) begin
            tok_d.hit   = 1'b1;
            tok_d.value = value_q;
          end
        end
        wnrl_pkg::OP_INSERT: begin
          if (match) begin
            tok_d.hit = 1'b1;
            wr_val    = 1'b1;
          end
          if (!valid_q) begin
            tok_d.free_seen = 1'b1;
          end
        end
        wnrl_pkg::OP_CLAIM: begin
          // first empty entry on the way takes the rule
          if (!valid_q && !tok_i.hit) begin
            valid_d   = 1'b1;
            wr_key    = 1'b1;
            wr_val    = 1'b1;
            tok_d.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_q <= tok_i.key[CELL_KEY_W-1:0];
    end
    if (wr_val) begin
      value_q <= tok_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/wnrl_chain.sv
// One rule store built as a row of cells that pass a token along.
module wnrl_chain #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned CELL_KEY_W = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wnrl_pkg::tok_t  tok_i,
  output wnrl_pkg::tok_t  tok_o
);

  wnrl_pkg::tok_t link [ENTRIES+1];

  assign link[0] = tok_i;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    wnrl_cell #(
      .CELL_KEY_W(CELL_KEY_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (link[g]),
      .tok_o (link[g+1])
    );
  end

  assign tok_o = link[ENTRIES];

endmodule

>>> rtl/wildcard_nat_rule_lookup.sv
// Top level of the wildcard NAT rule lookup: three rule stores and their sequencer.
//
//  channel  dir  handshake            tdata / tuser
//  -------  ---  -------------------  ----------------------------------------------
//  s_*      in   s_tvalid_i/tready_o  key, wildcards, new address; tuser = mode
//  m_*      out  m_tvalid_o/tready_i  translated address; tuser = status, match kind
//
// One item is in flight at a time. A token walks each store one cell per cycle;
// all three stores are walked side by side on a lookup. An insert walks only its
// own store, plus a second walk when a new key claims the lowest empty entry. A rule
// with both wildcards answers without walking any store. Reset clears every valid
// bit at once; there is no clearing pass. A stalled result word holds in the output
// register while the next input word is taken.
module wildcard_nat_rule_lookup #(
  parameter int unsigned EXACT_ENTRIES    = 64,
  parameter int unsigned IPONLY_ENTRIES   = 64,
  parameter int unsigned PORTONLY_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  // [31:0] key_ip, [47:32] key_port, [48] ip_any, [49] port_any,
  // [81:50] new_ip, [97:82] new_port, [103:98] zero
  input  logic [103:0]  s_tdata_i,
  // [0] mode
  input  logic [0:0]    s_tuser_i,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  // [31:0] out_ip, [47:32] out_port
  output logic [47:0]   m_tdata_o,
  // [1:0] status, [3:2] match_kind
  output logic [3:0]    m_tuser_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_CLAIM = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam int unsigned IP_W   = wnrl_pkg::IP_W;
  localparam int unsigned PORT_W = wnrl_pkg::PORT_W;
  localparam int unsigned VAL_W  = wnrl_pkg::VAL_W;
  localparam int unsigned KEY_W  = wnrl_pkg::KEY_W;
  localparam int unsigned NS     = wnrl_pkg::NUM_STORES;

  // control
  logic [1:0]     state_q, state_d;
  logic [NS-1:0]  need_q, need_d;
  logic [NS-1:0]  done_q, done_d;
  logic           out_valid_q, out_valid_d;
  wnrl_pkg::tok_t launch_q [NS];
  wnrl_pkg::tok_t launch_d [NS];
  wnrl_pkg::tok_t exit_w   [NS];

  // payload
  logic                          mode_q, mode_d;
  logic [wnrl_pkg::STORE_W-1:0]  sel_q, sel_d;
  logic [IP_W-1:0]               key_ip_q, key_ip_d;
  logic [PORT_W-1:0]             key_port_q, key_port_d;
  logic [VAL_W-1:0]              new_val_q, new_val_d;
  logic [NS-1:0]                 hit_q, hit_d;
  logic [NS-1:0]                 free_q, free_d;
  logic [VAL_W-1:0]              val_q [NS];
  logic [VAL_W-1:0]              val_d [NS];
  logic [1:0]                    res_status_q, res_status_d;
  logic [1:0]                    res_kind_q, res_kind_d;
  logic [VAL_W-1:0]              res_val_q, res_val_d;
  logic [47:0]                   out_data_q, out_data_d;
  logic [3:0]                    out_user_q, out_user_d;

  // input word fields
  logic                 in_mode;
  logic [IP_W-1:0]      in_ip;
  logic [PORT_W-1:0]    in_port;
  logic                 in_ip_any;
  logic                 in_port_any;
  logic [VAL_W-1:0]     in_val;
  logic                 accept;

  assign in_mode     = s_tuser_i[0];
  assign in_ip       = s_tdata_i[31:0];
  assign in_port     = s_tdata_i[47:32];
  assign in_ip_any   = s_tdata_i[48];
  assign in_port_any = s_tdata_i[49];
  assign in_val      = {s_tdata_i[81:50], s_tdata_i[97:82]};

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  // Form the search key of one store; narrow stores use the low bits.
  function automatic logic [KEY_W-1:0] store_key(
    input logic [wnrl_pkg::STORE_W-1:0] store,
    input logic [IP_W-1:0]              ip,
    input logic [PORT_W-1:0]            port
  );
    logic [KEY_W-1:0] k;
    case (store)
      wnrl_pkg::STORE_EXACT:    k = {ip, port};
      wnrl_pkg::STORE_IPONLY:   k = {{(KEY_W-IP_W){1'b0}}, ip};
      wnrl_pkg::STORE_PORTONLY: k = {{(KEY_W-PORT_W){1'b0}}, port};
      default:                  k = '0;
    endcase
    return k;
  endfunction

  function automatic wnrl_pkg::tok_t make_tok(
    input wnrl_pkg::op_e      op,
    input logic [KEY_W-1:0]   key,
    input logic [VAL_W-1:0]   value
  );
    wnrl_pkg::tok_t t;
    t           = '0;
    t.active    = 1'b1;
    t.op        = op;
    t.key       = key;
    t.value     = value;
    return t;
  endfunction

  always_comb begin
    state_d      = state_q;
    need_d       = need_q;
    done_d       = done_q;
    out_valid_d  = out_valid_q;
    mode_d       = mode_q;
    sel_d        = sel_q;
    key_ip_d     = key_ip_q;
    key_port_d   = key_port_q;
    new_val_d    = new_val_q;
    hit_d        = hit_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_kind_d   = res_kind_q;
    res_val_d    = res_val_q;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    for (int c = 0; c < NS; c++) begin
      launch_d[c] = '0;
      val_d[c]    = val_q[c];
    end

    // Capture each token as it leaves the end of its store.
    for (int c = 0; c < NS; c++) begin
      if (exit_w[c].active) begin
        done_d[c] = 1'b1;
        hit_d[c]  = exit_w[c].hit;
        free_d[c] = exit_w[c].free_seen;
        val_d[c]  = exit_w[c].value;
      end
    end

    // Drop the output word once taken.
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d     = in_mode;
          key_ip_d   = in_ip;
          key_port_d = in_port;
          new_val_d  = in_val;
          done_d     = '0;
          if (in_mode == wnrl_pkg::MODE_LOOKUP) begin
            for (int c = 0; c < NS; c++) begin
              launch_d[c] = make_tok(wnrl_pkg::OP_LOOKUP,
                                     store_key(wnrl_pkg::STORE_W'(c), in_ip, in_port),
                                     '0);
            end
            need_d  = '1;
            state_d = S_SCAN;
          end else if (in_ip_any && in_port_any) begin
            // rule can never match: ignore it
            res_status_d = wnrl_pkg::ST_STORED;
            res_kind_d   = '0;
            res_val_d    = '0;
            state_d      = S_RESP;
          end else begin
            if (in_ip_any) begin
              sel_d = wnrl_pkg::STORE_PORTONLY;
            end else if (in_port_any) begin
              sel_d = wnrl_pkg::STORE_IPONLY;
            end else begin
              sel_d = wnrl_pkg::STORE_EXACT;
            end
            launch_d[sel_d] = make_tok(wnrl_pkg::OP_INSERT,
                                       store_key(sel_d, in_ip, in_port), in_val);
            need_d          = '0;
            need_d[sel_d]   = 1'b1;
            state_d         = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if ((done_q & need_q) == need_q) begin
          res_kind_d = '0;
          res_val_d  = '0;
          state_d    = S_RESP;
          if (mode_q == wnrl_pkg::MODE_LOOKUP) begin
            // exact first, then IP-only, then port-only
            res_status_d = wnrl_pkg::ST_HIT;
            if (hit_q[wnrl_pkg::STORE_EXACT]) begin
              res_kind_d = wnrl_pkg::STORE_EXACT;
              res_val_d  = val_q[wnrl_pkg::STORE_EXACT];
            end else if (hit_q[wnrl_pkg::STORE_IPONLY]) begin
              res_kind_d = wnrl_pkg::STORE_IPONLY;
              res_val_d  = val_q[wnrl_pkg::STORE_IPONLY];
            end else if (hit_q[wnrl_pkg::STORE_PORTONLY]) begin
              res_kind_d = wnrl_pkg::STORE_PORTONLY;
              res_val_d  = val_q[wnrl_pkg::STORE_PORTONLY];
            end else begin
              res_status_d = wnrl_pkg::ST_MISS;
            end
          end else if (hit_q[sel_q]) begin
            // existing key: value already overwritten in place
            res_status_d = wnrl_pkg::ST_STORED;
          end else if (free_q[sel_q]) begin
            // new key: send a second token to claim the lowest empty entry
            launch_d[sel_q] = make_tok(wnrl_pkg::OP_CLAIM,
                                       store_key(sel_q, key_ip_q, key_port_q), new_val_q);
            done_d  = '0;
            state_d = S_CLAIM;
          end else begin
            res_status_d = wnrl_pkg::ST_FULL;
          end
        end
      end

      S_CLAIM: begin
        if (done_q[sel_q]) begin
          res_status_d = wnrl_pkg::ST_STORED;
          state_d      = S_RESP;
        end
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {res_val_q[PORT_W-1:0], res_val_q[VAL_W-1:PORT_W]};
          out_user_d  = {res_kind_q, res_status_q};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      need_q      <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NS; c++) begin
        launch_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      need_q      <= need_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      for (int c = 0; c < NS; c++) begin
        launch_q[c] <= launch_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    sel_q        <= sel_d;
    key_ip_q     <= key_ip_d;
    key_port_q   <= key_port_d;
    new_val_q    <= new_val_d;
    hit_q        <= hit_d;
    free_q       <= free_d;
    res_status_q <= res_status_d;
    res_kind_q   <= res_kind_d;
    res_val_q    <= res_val_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
    for (int c = 0; c < NS; c++) begin
      val_q[c] <= val_d[c];
    end
  end

  // Rule stores: exact key on IP and port, IP with any port, port with any IP.
  wnrl_chain #(
    .ENTRIES   (EXACT_ENTRIES),
    .CELL_KEY_W(IP_W + PORT_W)
  ) u_exact (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (launch_q[wnrl_pkg::STORE_EXACT]),
    .tok_o (exit_w[wnrl_pkg::STORE_EXACT])
  );

  wnrl_chain #(
    .ENTRIES   (IPONLY_ENTRIES),
    .CELL_KEY_W(IP_W)
  ) u_iponly (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (launch_q[wnrl_pkg::STORE_IPONLY]),
    .tok_o (exit_w[wnrl_pkg::STORE_IPONLY])
  );

  wnrl_chain #(
    .ENTRIES   (PORTONLY_ENTRIES),
    .CELL_KEY_W(PORT_W)
  ) u_portonly (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (launch_q[wnrl_pkg::STORE_PORTONLY]),
    .tok_o (exit_w[wnrl_pkg::STORE_PORTONLY])
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the wildcard NAT rule lookup block.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned POOL       = 72;   // more keys than entries, so stores fill up
  localparam int unsigned RAND_WORDS = 950;
  localparam int unsigned IDLE_LIMIT = 3000; // cycles without any accepted word
  localparam int unsigned DRAIN      = 150;  // longest insert walk plus margin

  // Match kind carried by inserts and misses.
  localparam logic [wnrl_pkg::STORE_W-1:0] KIND_NONE = wnrl_pkg::STORE_EXACT;

  typedef struct packed {
    logic                        mode;
    logic [wnrl_pkg::IP_W-1:0]   key_ip;
    logic [wnrl_pkg::PORT_W-1:0] key_port;
    logic                        ip_any;
    logic                        port_any;
    logic [wnrl_pkg::IP_W-1:0]   new_ip;
    logic [wnrl_pkg::PORT_W-1:0] new_port;
  } flow_word_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [wnrl_pkg::STORE_W-1:0] kind;
    logic [wnrl_pkg::IP_W-1:0]    ip;
    logic [wnrl_pkg::PORT_W-1:0]  port;
  } xlat_t;

  typedef struct {
    flow_word_t w;
    bit         typed;
    xlat_t      res;
  } dir_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_tvalid_i = 1'b0;
  logic          s_tready_o;
  logic [103:0]  s_tdata_i = '0;
  logic [0:0]    s_tuser_i = '0;
  logic          m_tvalid_o;
  logic          m_tready_i = 1'b0;
  logic [47:0]   m_tdata_o;
  logic [3:0]    m_tuser_o;

  wildcard_nat_rule_lookup #(
    .EXACT_ENTRIES   (ENTRIES),
    .IPONLY_ENTRIES  (ENTRIES),
    .PORTONLY_ENTRIES(ENTRIES)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the three rule stores, indexed by store code.
  logic [wnrl_pkg::KEY_W-1:0] rule_key [wnrl_pkg::NUM_STORES][ENTRIES];
  logic [wnrl_pkg::VAL_W-1:0] rule_val [wnrl_pkg::NUM_STORES][ENTRIES];
  bit                         rule_vld [wnrl_pkg::NUM_STORES][ENTRIES];

  xlat_t    xlat_q[$];     // translations still owed by the block
  dir_row_t typed_q[$];    // per presented word: hand-typed result, if any
  dir_row_t dir_q[$];      // directed stimulus table

  logic [wnrl_pkg::IP_W-1:0]   ip_pool   [POOL];
  logic [wnrl_pkg::PORT_W-1:0] port_pool [POOL];
  int unsigned                 seq_idx   [wnrl_pkg::NUM_STORES];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_cyc = 0;
  int unsigned rx_stall = 0;

  // Key as each store holds it: IP and port, IP alone, or port alone.
  function automatic logic [wnrl_pkg::KEY_W-1:0] key_for(logic [wnrl_pkg::STORE_W-1:0] st,
                                                         flow_word_t w);
    case (st)
      wnrl_pkg::STORE_EXACT:  return {w.key_ip, w.key_port};
      wnrl_pkg::STORE_IPONLY: return {16'b0, w.key_ip};
      default:                return {32'b0, w.key_port};
    endcase
  endfunction

  function automatic int find_rule(logic [wnrl_pkg::STORE_W-1:0] st,
                                   logic [wnrl_pkg::KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (rule_vld[st][i] && rule_key[st][i] == key) return i;
    return -1;
  endfunction

  // Overwrite a present key, else claim the lowest free entry, else report full.
  function automatic logic [1:0] place_rule(logic [wnrl_pkg::STORE_W-1:0] st,
                                            logic [wnrl_pkg::KEY_W-1:0] key,
                                            logic [wnrl_pkg::VAL_W-1:0] val);
    int i;
    i = find_rule(st, key);
    if (i < 0) begin
      for (int j = ENTRIES - 1; j >= 0; j--)
        if (!rule_vld[st][j]) i = j;
      if (i < 0) return wnrl_pkg::ST_FULL;
      rule_key[st][i] = key;
      rule_vld[st][i] = 1'b1;
    end
    rule_val[st][i] = val;
    return wnrl_pkg::ST_STORED;
  endfunction

  function automatic xlat_t translate(flow_word_t w);
    xlat_t                        r;
    logic [wnrl_pkg::STORE_W-1:0] st;
    int                           i;
    r = '0;
    if (w.mode == wnrl_pkg::MODE_INSERT) begin
      // A rule with both wildcards is accepted but never stored.
      if (w.ip_any && w.port_any) begin
        r.status = wnrl_pkg::ST_STORED;
      end else begin
        st = w.ip_any ? wnrl_pkg::STORE_PORTONLY
                      : (w.port_any ? wnrl_pkg::STORE_IPONLY : wnrl_pkg::STORE_EXACT);
        r.status = place_rule(st, key_for(st, w), {w.new_ip, w.new_port});
      end
    end else begin
      // Store codes run in priority order: exact, IP-only, port-only.
      r.status = wnrl_pkg::ST_MISS;
      for (int k = 0; k < wnrl_pkg::NUM_STORES; k++) begin
        st = k[wnrl_pkg::STORE_W-1:0];
        i = (r.status == wnrl_pkg::ST_MISS) ? find_rule(st, key_for(st, w)) : -1;
        if (i >= 0) begin
          r.status = wnrl_pkg::ST_HIT;
          r.kind = st;
          {r.ip, r.port} = rule_val[st][i];
        end
      end
    end
    return r;
  endfunction

  function automatic flow_word_t make_flow();
    flow_word_t  w;
    int unsigned pick;
    int unsigned idx;
    logic [wnrl_pkg::STORE_W-1:0] st;
    w.mode     = wnrl_pkg::MODE_LOOKUP;
    w.key_ip   = $urandom;
    w.key_port = 16'($urandom);
    w.ip_any   = 1'($urandom);
    w.port_any = 1'($urandom);
    w.new_ip   = $urandom;
    w.new_port = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Noise: every field random, mode included.
      w.mode = 1'($urandom);
      return w;
    end
    if (pick < 55) begin
      w.mode = wnrl_pkg::MODE_INSERT;
      pick = $urandom_range(0, 99);
      if (pick >= 85) return w;  // leave both wildcards as drawn
      st = (pick < 35) ? wnrl_pkg::STORE_EXACT
                       : ((pick < 60) ? wnrl_pkg::STORE_IPONLY : wnrl_pkg::STORE_PORTONLY);
      w.ip_any   = (st == wnrl_pkg::STORE_PORTONLY);
      w.port_any = (st == wnrl_pkg::STORE_IPONLY);
      // Half the inserts sweep the pool so that every store runs full.
      if ($urandom_range(0, 1)) begin
        idx = seq_idx[st] % POOL;
        seq_idx[st]++;
      end else begin
        idx = $urandom_range(0, POOL - 1);
      end
    end else begin
      idx = $urandom_range(0, POOL - 1);
      pick = $urandom_range(0, 99);
      st = (pick < 40) ? wnrl_pkg::STORE_EXACT
                       : ((pick < 65) ? wnrl_pkg::STORE_IPONLY : wnrl_pkg::STORE_PORTONLY);
      if (pick >= 90) return w;  // flow likely to miss everywhere
    end
    if (st != wnrl_pkg::STORE_PORTONLY) w.key_ip = ip_pool[idx];
    if (st == wnrl_pkg::STORE_EXACT) w.key_port = port_pool[(idx * 5 + 1) % POOL];
    if (st == wnrl_pkg::STORE_PORTONLY) w.key_port = port_pool[idx];
    return w;
  endfunction

  task automatic add_row(input logic mode, input logic [31:0] kip, input logic [15:0] kport,
                         input logic ipany, input logic portany, input logic [31:0] nip,
                         input logic [15:0] nport, input bit typed, input logic [1:0] status,
                         input logic [1:0] kind, input logic [31:0] oip,
                         input logic [15:0] oport);
    dir_row_t row;
    row.w     = '{mode, kip, kport, ipany, portany, nip, nport};
    row.typed = typed;
    row.res   = '{status, kind, oip, oport};
    dir_q.push_back(row);
  endtask

  // Present one word and hold it until the block takes it.
  task automatic present(input flow_word_t w, input bit typed, input xlat_t res);
    dir_row_t row;
    row.w     = w;
    row.typed = typed;
    row.res   = res;
    typed_q.push_back(row);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= w.mode;
    s_tdata_i  <= {6'b0, w.new_port, w.new_ip, w.port_any, w.ip_any, w.key_port, w.key_ip};
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // Receiver: cycle through always ready, random, bursts of long stalls, toggling.
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 300) % 4)
      0: m_tready_i <= 1'b1;
      1: m_tready_i <= ($urandom_range(0, 3) != 0);
      2: begin
        if (rx_stall != 0) begin
          m_tready_i <= 1'b0;
          rx_stall   <= rx_stall - 1;
        end else begin
          m_tready_i <= 1'b1;
          rx_stall   <= ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0;
        end
      end
      default: m_tready_i <= rx_cyc[0];
    endcase
  end

  // Predict on every accepted input word, check every accepted result word.
  always @(posedge clk_i) begin
    flow_word_t w;
    dir_row_t   row;
    xlat_t      pred;
    xlat_t      got;
    xlat_t      want;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_tvalid_i && s_tready_o) begin
        moved = 1'b1;
        w = {s_tuser_i[0], s_tdata_i[31:0], s_tdata_i[47:32], s_tdata_i[48], s_tdata_i[49],
             s_tdata_i[81:50], s_tdata_i[97:82]};
        pred = translate(w);
        row = typed_q.pop_front();
        xlat_q.push_back(row.typed ? row.res : pred);
      end
      if (m_tvalid_o && m_tready_i) begin
        moved = 1'b1;
        got = {m_tuser_o[1:0], m_tuser_o[3:2], m_tdata_o[31:0], m_tdata_o[47:32]};
        if (xlat_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d kind=%0d ip=%h port=%h",
                   $time, got.status, got.kind, got.ip, got.port);
          errors++;
        end else begin
          want = xlat_q.pop_front();
          if (got.status !== want.status || got.kind !== want.kind ||
              got.ip !== want.ip || got.port !== want.port) begin
            $display("%0t: mismatch expected status=%0d kind=%0d ip=%h port=%h", $time,
                     want.status, want.kind, want.ip, want.port);
            $display("%0t:          actual   status=%0d kind=%0d ip=%h port=%h", $time,
                     got.status, got.kind, got.ip, got.port);
            errors++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, xlat_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    flow_word_t  w;
    dir_row_t    row;
    int unsigned burst;
    int unsigned total;

    for (int k = 0; k < POOL; k++) begin
      ip_pool[k]        = $urandom;
      ip_pool[k][6:0]   = 7'(k);   // low bits keep the pool keys distinct
      port_pool[k]      = 16'($urandom);
      port_pool[k][6:0] = 7'(k);
    end
    for (int k = 0; k < wnrl_pkg::NUM_STORES; k++) seq_idx[k] = $urandom_range(0, POOL - 1);

    // Empty table, lookups ignore the rule fields, double wildcard ignored.
    add_row(wnrl_pkg::MODE_LOOKUP, 32'h0, 16'h0, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_MISS, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 16'hFFFF,
            1'b1, wnrl_pkg::ST_MISS, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_INSERT, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 16'hFFFF,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_MISS, KIND_NONE, 32'h0, 16'h0);
    // Exact rules at the extremes of the key and the translation.
    add_row(wnrl_pkg::MODE_INSERT, 32'h0, 16'h0, 1'b0, 1'b0, 32'hFFFFFFFF, 16'hFFFF,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'h0, 16'h0, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_EXACT, 32'hFFFFFFFF, 16'hFFFF);
    add_row(wnrl_pkg::MODE_INSERT, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b0, 32'h12345678, 16'h9ABC,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_EXACT, 32'h0, 16'h0);
    // IP with any port, then port with any IP.
    add_row(wnrl_pkg::MODE_INSERT, 32'hC0A80001, 16'h1234, 1'b0, 1'b1, 32'h0A000001, 16'h0050,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hC0A80001, 16'h9999, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_IPONLY, 32'h0A000001, 16'h0050);
    add_row(wnrl_pkg::MODE_INSERT, 32'h0BADBEEF, 16'h0050, 1'b1, 1'b0, 32'h0A000002, 16'h1F90,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'h01020304, 16'h0050, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_PORTONLY, 32'h0A000002, 16'h1F90);
    // Priority: exact over IP-only and port-only.
    add_row(wnrl_pkg::MODE_INSERT, 32'hC0A80001, 16'h0050, 1'b0, 1'b0, 32'h0A000003, 16'h0BB8,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hC0A80001, 16'h0050, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_EXACT, 32'h0A000003, 16'h0BB8);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hC0A80001, 16'h0051, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_IPONLY, 32'h0A000001, 16'h0050);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'h08080808, 16'h0050, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_PORTONLY, 32'h0A000002, 16'h1F90);
    // Overwrite of a present key.
    add_row(wnrl_pkg::MODE_INSERT, 32'hC0A80001, 16'h0050, 1'b0, 1'b0, 32'h0A0000FF, 16'hAAAA,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hC0A80001, 16'h0050, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_EXACT, 32'h0A0000FF, 16'hAAAA);
    // Wildcard rules on all-ones and all-zeros keys.
    add_row(wnrl_pkg::MODE_INSERT, 32'hFFFFFFFF, 16'h0000, 1'b0, 1'b1, 32'hAAAAAAAA, 16'h5555,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'hFFFFFFFF, 16'h1234, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_IPONLY, 32'hAAAAAAAA, 16'h5555);
    add_row(wnrl_pkg::MODE_INSERT, 32'h00000000, 16'h0000, 1'b1, 1'b0, 32'h55555555, 16'hAAAA,
            1'b1, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'h12345678, 16'h0000, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_HIT, wnrl_pkg::STORE_PORTONLY, 32'h55555555, 16'hAAAA);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'h00000001, 16'h0001, 1'b0, 1'b0, 32'h0, 16'h0,
            1'b1, wnrl_pkg::ST_MISS, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_INSERT, 32'h9ABCDEF0, 16'h7777, 1'b0, 1'b0, 32'h13579BDF, 16'h2468,
            1'b0, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);
    add_row(wnrl_pkg::MODE_LOOKUP, 32'h9ABCDEF0, 16'h7777, 1'b1, 1'b1, 32'h0, 16'h0,
            1'b0, wnrl_pkg::ST_STORED, KIND_NONE, 32'h0, 16'h0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    total = dir_q.size() + RAND_WORDS;
    burst = $urandom_range(1, 6);
    for (int unsigned k = 0; k < total; k++) begin
      if (k == dir_q.size() + RAND_WORDS / 2) begin
        // Hold off until the block has handed back every translation.
        s_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (xlat_q.size() != 0) @(posedge clk_i);
      end else if (burst == 0) begin
        s_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
      if (burst != 0) burst--;
      if (k < dir_q.size()) begin
        row = dir_q[k];
        present(row.w, row.typed, row.res);
      end else begin
        w = make_flow();
        present(w, 1'b0, '0);
      end
    end
    s_tvalid_i <= 1'b0;

    while (xlat_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
